@@ sv/command_frame_receiver_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the command frame receiver
// Immediate-implication and next-cycle checks on the rising clock edge.
// ---------------------------------------------------------------------------
`ifndef COMMAND_FRAME_RECEIVER_ASSERT_SVH
`define COMMAND_FRAME_RECEIVER_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define CFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfr assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfr assertion failed");

`endif

@@ sv/cfr_pkg.sv @@
// ---------------------------------------------------------------------------
// cfr_pkg
// Frame constants, command codes and matcher positions for the receiver.
// ---------------------------------------------------------------------------
package cfr_pkg;

  localparam logic [7:0] SYNC0  = 8'h00;
  localparam logic [7:0] SYNC1  = 8'hAA;
  localparam logic [7:0] SYNC2  = 8'hEE;
  localparam logic [7:0] TRAIL0 = 8'hEF;
  localparam logic [7:0] TRAIL1 = 8'hAB;
  localparam logic [7:0] TRAIL2 = 8'h01;

  localparam logic [7:0] CMD_MAX   = 8'h14;
  localparam logic [7:0] LEVEL_MAX = 8'd10;

  typedef enum logic [4:0] {
    CMD_DEV0   = 5'd0,
    CMD_DEV1   = 5'd1,
    CMD_DEV2   = 5'd2,
    CMD_DEV3   = 5'd3,
    CMD_FAN    = 5'd4,
    CMD_HEATER = 5'd5,
    CMD_FERT   = 5'd6,
    CMD_WATER  = 5'd7,
    CMD_LIGHT  = 5'd8,
    CMD_COLOR  = 5'd9,
    CMD_LEVEL  = 5'd10
  } cmd_code_t;

  typedef enum logic [3:0] {
    POS_SYNC0  = 4'd0,
    POS_SYNC1  = 4'd1,
    POS_SYNC2  = 4'd2,
    POS_CMD    = 4'd3,
    POS_HIGH   = 4'd4,
    POS_LOW    = 4'd5,
    POS_TRAIL0 = 4'd6,
    POS_TRAIL1 = 4'd7,
    POS_TRAIL2 = 4'd8
  } pos_t;

  localparam logic [0:0] REG_FERT_TICKS  = 1'b0;
  localparam logic [0:0] REG_WATER_TICKS = 1'b1;

  localparam logic [15:0] TICKS_RESET = 16'd100;

endpackage

@@ sv/command_frame_receiver.sv @@
// A word accepted at one edge shows its result word on the next cycle.
// Throughput: one word per cycle while the consumer takes result words; a word
// can enter while the consumer empties the result register in the same cycle.
// Reset (rst_n low, synchronous): matcher to start, all device and pump state
// cleared, both tick registers back to 100.
// ---------------------------------------------------------------------------
// command_frame_receiver
// Echoes received bytes, matches nine-byte command frames and runs pump timers.
// ---------------------------------------------------------------------------
`include "command_frame_receiver_assert.svh"

module command_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] command (0 byte, 1 tick)
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] echo_byte, [12:8] command_code, [28:13] command_value,
  // [32:29] device_mask, [33] fan_on, [34] heater_on, [41:35] light_duty,
  // [49:42] light_color, [50] fertilizer_on, [51] water_on, [55:52] zero
  output logic [55:0] out_tdata,
  output logic [1:0]  out_tuser   // [0] echo_valid, [1] frame_accepted
);
  import cfr_pkg::*;

  logic [15:0] fert_ticks_r, water_ticks_r;

  pos_t        pos_r, pos_nxt;
  logic [4:0]  held_cmd_r, held_cmd_nxt;
  logic [7:0]  held_high_r, held_high_nxt;
  logic [7:0]  held_low_r, held_low_nxt;
  logic [3:0]  dev_bits_r, dev_bits_nxt;
  logic        fan_r, fan_nxt;
  logic        heater_r, heater_nxt;
  logic        light_r, light_nxt;
  logic [7:0]  color_r, color_nxt;
  logic [7:0]  level_r, level_nxt;
  logic [15:0] fert_cnt_r, fert_cnt_nxt;
  logic [15:0] water_cnt_r, water_cnt_nxt;
  logic        fert_mot_r, fert_mot_nxt;
  logic        water_mot_r, water_mot_nxt;

  logic        out_valid_r;
  logic [55:0] out_data_r, out_data_nxt;
  logic [1:0]  out_user_r, out_user_nxt;

  logic        accept;
  logic        is_tick;
  logic [7:0]  rx;
  logic        done;
  logic        on;
  logic [3:0]  dev_bit;
  logic [3:0]  level_clamped;
  logic [6:0]  duty;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign is_tick    = in_tuser[0];
  assign rx         = in_tdata;
  assign on         = (held_low_r != 8'd0);
  assign dev_bit    = 4'b0001 << held_cmd_r[1:0];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fert_ticks_r  <= TICKS_RESET;
      water_ticks_r <= TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FERT_TICKS:  fert_ticks_r  <= cfg_wdata;
        REG_WATER_TICKS: water_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // matcher, device state and pump timers
  always_comb begin
    pos_nxt       = pos_r;
    held_cmd_nxt  = held_cmd_r;
    held_high_nxt = held_high_r;
    held_low_nxt  = held_low_r;
    dev_bits_nxt  = dev_bits_r;
    fan_nxt       = fan_r;
    heater_nxt    = heater_r;
    light_nxt     = light_r;
    color_nxt     = color_r;
    level_nxt     = level_r;
    fert_cnt_nxt  = fert_cnt_r;
    water_cnt_nxt = water_cnt_r;
    fert_mot_nxt  = fert_mot_r;
    water_mot_nxt = water_mot_r;
    done          = 1'b0;

    if (is_tick) begin
      fert_mot_nxt  = (fert_cnt_r != 16'd0);
      water_mot_nxt = (water_cnt_r != 16'd0);
      if (fert_cnt_r != 16'd0) fert_cnt_nxt = fert_cnt_r - 16'd1;
      if (water_cnt_r != 16'd0) water_cnt_nxt = water_cnt_r - 16'd1;
    end else begin
      // a failing byte drops back to the start and is not re-examined
      pos_nxt = POS_SYNC0;
      unique case (pos_r)
        POS_SYNC0:  if (rx == SYNC0) pos_nxt = POS_SYNC1;
        POS_SYNC1:  if (rx == SYNC1) pos_nxt = POS_SYNC2;
        POS_SYNC2:  if (rx == SYNC2) pos_nxt = POS_CMD;
        POS_CMD: begin
          if (rx <= CMD_MAX) begin
            held_cmd_nxt = rx[4:0];
            pos_nxt      = POS_HIGH;
          end
        end
        POS_HIGH: begin
          held_high_nxt = rx;
          pos_nxt       = POS_LOW;
        end
        POS_LOW: begin
          held_low_nxt = rx;
          pos_nxt      = POS_TRAIL0;
        end
        POS_TRAIL0: if (rx == TRAIL0) pos_nxt = POS_TRAIL1;
        POS_TRAIL1: if (rx == TRAIL1) pos_nxt = POS_TRAIL2;
        POS_TRAIL2: done = (rx == TRAIL2);
        default: ;
      endcase

      if (done) begin
        unique case (held_cmd_r)
          CMD_DEV0, CMD_DEV1, CMD_DEV2, CMD_DEV3:
            dev_bits_nxt = on ? (dev_bits_r | dev_bit) : (dev_bits_r & ~dev_bit);
          CMD_FAN:    fan_nxt       = on;
          CMD_HEATER: heater_nxt    = on;
          CMD_FERT:   fert_cnt_nxt  = on ? fert_ticks_r : 16'd0;
          CMD_WATER:  water_cnt_nxt = on ? water_ticks_r : 16'd0;
          CMD_LIGHT:  light_nxt     = on;
          CMD_COLOR:  color_nxt     = held_low_r;
          CMD_LEVEL:  level_nxt     = held_low_r;
          default: ;  // report only, no state changes
        endcase
      end
    end

    level_clamped = (level_nxt > LEVEL_MAX) ? LEVEL_MAX[3:0] : level_nxt[3:0];
    duty          = light_nxt ? {level_clamped, 3'b000} : 7'd0;

    out_data_nxt = {4'd0, water_mot_nxt, fert_mot_nxt, color_nxt, duty,
                    heater_nxt, fan_nxt, dev_bits_nxt,
                    done ? {held_high_r, held_low_r} : 16'd0,
                    done ? held_cmd_r : 5'd0,
                    is_tick ? 8'd0 : rx};
    out_user_nxt = {done, !is_tick};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_SYNC0;
      held_cmd_r  <= '0;
      held_high_r <= '0;
      held_low_r  <= '0;
      dev_bits_r  <= '0;
      fan_r       <= 1'b0;
      heater_r    <= 1'b0;
      light_r     <= 1'b0;
      color_r     <= '0;
      level_r     <= '0;
      fert_cnt_r  <= '0;
      water_cnt_r <= '0;
      fert_mot_r  <= 1'b0;
      water_mot_r <= 1'b0;
    end else if (accept) begin
      pos_r       <= pos_nxt;
      held_cmd_r  <= held_cmd_nxt;
      held_high_r <= held_high_nxt;
      held_low_r  <= held_low_nxt;
      dev_bits_r  <= dev_bits_nxt;
      fan_r       <= fan_nxt;
      heater_r    <= heater_nxt;
      light_r     <= light_nxt;
      color_r     <= color_nxt;
      level_r     <= level_nxt;
      fert_cnt_r  <= fert_cnt_nxt;
      water_cnt_r <= water_cnt_nxt;
      fert_mot_r  <= fert_mot_nxt;
      water_mot_r <= water_mot_nxt;
    end
  end

  // result register: refilled on accept, emptied when the word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  `CFR_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, out_valid_r && !out_tready, !in_tready)
  `CFR_ASSERT_NOW(a_frame_is_byte, clk, rst_n, out_valid_r && out_user_r[1], out_user_r[0])
  `CFR_ASSERT_NEXT(a_tick_motor, clk, rst_n, accept && is_tick,
                   out_data_r[50] == (($past(fert_cnt_r)) != 16'd0))
  `CFR_ASSERT_NOW(a_duty_range, clk, rst_n, out_valid_r, out_data_r[41:35] <= 7'd80)

endmodule

@@ verif/testbench.sv @@
// ---------------------------------------------------------------------------
// Command frame receiver testbench
// Drives received bytes and timer ticks into the receiver with bursty input
// and a stalling result side, predicts every result word from a behavioural
// copy of the matcher, device and pump state, and checks each field.
// ---------------------------------------------------------------------------
module testbench;
  import cfr_pkg::*;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam int   CYCLE_LIMIT = 300000;
  localparam int   PHASE_WORDS = 320;
  localparam int   REPORT_MAX = 10;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_SLOW, RX_TOGGLE} rx_mode_t;

  // result word: tdata fields above, tuser bits in the lowest two
  typedef struct packed {
    logic [3:0]  pad;
    logic        water_on;
    logic        fertilizer_on;
    logic [7:0]  light_color;
    logic [6:0]  light_duty;
    logic        heater_on;
    logic        fan_on;
    logic [3:0]  device_mask;
    logic [15:0] command_value;
    logic [4:0]  command_code;
    logic [7:0]  echo_byte;
    logic        frame_accepted;
    logic        echo_valid;
  } status_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;

  command_frame_receiver i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted receiver state
  logic [15:0] fert_reload, water_reload;
  pos_t        match_pos;
  logic [4:0]  held_cmd;
  logic [7:0]  held_hi, held_lo;
  logic [3:0]  dev_bits;
  logic        fan_st, heater_st, light_st;
  logic [7:0]  color_st, level_st;
  logic [15:0] fert_left, water_left;
  logic        fert_motor, water_motor;

  status_word_t pending_status[$];
  int           error_count = 0;
  int           word_count = 0;
  int           burst_left = 0;
  int           cycle_count = 0;
  rx_mode_t     rx_mode = RX_FREE;
  int           rx_left = 0;

  function automatic void clear_receiver_state();
    fert_reload = TICKS_RESET;
    water_reload = TICKS_RESET;
    match_pos = POS_SYNC0;
    held_cmd = '0;
    held_hi = '0;
    held_lo = '0;
    dev_bits = '0;
    fan_st = 1'b0;
    heater_st = 1'b0;
    light_st = 1'b0;
    color_st = '0;
    level_st = '0;
    fert_left = '0;
    water_left = '0;
    fert_motor = 1'b0;
    water_motor = 1'b0;
  endfunction

  function automatic void run_frame_command();
    logic on;
    on = (held_lo != 8'd0);
    case (held_cmd)
      CMD_DEV0, CMD_DEV1, CMD_DEV2, CMD_DEV3: dev_bits[held_cmd[1:0]] = on;
      CMD_FAN:    fan_st = on;
      CMD_HEATER: heater_st = on;
      CMD_FERT:   fert_left = on ? fert_reload : 16'd0;
      CMD_WATER:  water_left = on ? water_reload : 16'd0;
      CMD_LIGHT:  light_st = on;
      CMD_COLOR:  color_st = held_lo;
      CMD_LEVEL:  level_st = held_lo;
      default: ;
    endcase
  endfunction

  function automatic status_word_t receiver_step(logic kind, logic [7:0] b);
    status_word_t s;
    pos_t         nxt;
    logic         done;
    logic [7:0]   lvl;
    done = 1'b0;
    if (kind == KIND_TICK) begin
      fert_motor = (fert_left != 16'd0);
      if (fert_motor) fert_left = fert_left - 16'd1;
      water_motor = (water_left != 16'd0);
      if (water_motor) water_left = water_left - 16'd1;
    end else begin
      // a failing byte drops back to the start and is not looked at again
      nxt = POS_SYNC0;
      case (match_pos)
        POS_SYNC0:  if (b == SYNC0) nxt = POS_SYNC1;
        POS_SYNC1:  if (b == SYNC1) nxt = POS_SYNC2;
        POS_SYNC2:  if (b == SYNC2) nxt = POS_CMD;
        POS_CMD: begin
          if (b <= CMD_MAX) begin
            held_cmd = b[4:0];
            nxt = POS_HIGH;
          end
        end
        POS_HIGH: begin
          held_hi = b;
          nxt = POS_LOW;
        end
        POS_LOW: begin
          held_lo = b;
          nxt = POS_TRAIL0;
        end
        POS_TRAIL0: if (b == TRAIL0) nxt = POS_TRAIL1;
        POS_TRAIL1: if (b == TRAIL1) nxt = POS_TRAIL2;
        POS_TRAIL2: done = (b == TRAIL2);
        default: ;
      endcase
      match_pos = nxt;
      if (done) run_frame_command();
    end
    lvl = (level_st > LEVEL_MAX) ? LEVEL_MAX : level_st;
    s.echo_valid     = (kind == KIND_BYTE);
    s.frame_accepted = done;
    s.echo_byte      = (kind == KIND_BYTE) ? b : 8'd0;
    s.command_code   = done ? held_cmd : 5'd0;
    s.command_value  = done ? {held_hi, held_lo} : 16'd0;
    s.device_mask    = dev_bits;
    s.fan_on         = fan_st;
    s.heater_on      = heater_st;
    s.light_duty     = light_st ? (lvl[6:0] << 3) : 7'd0;
    s.light_color    = color_st;
    s.fertilizer_on  = fert_motor;
    s.water_on       = water_motor;
    s.pad            = 4'd0;
    return s;
  endfunction

  // every accepted input word queues its predicted status
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      pending_status.push_back(receiver_step(in_tuser[0], in_tdata));
  end

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      if (error_count <= REPORT_MAX)
        $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    status_word_t exp_s, act_s;
    if (rst_n && out_tvalid && out_tready) begin
      act_s = {out_tdata, out_tuser};
      if (pending_status.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("unexpected result word %h", act_s);
      end else begin
        exp_s = pending_status.pop_front();
        check_field("echo_valid", 16'(exp_s.echo_valid), 16'(act_s.echo_valid));
        check_field("frame_accepted", 16'(exp_s.frame_accepted),
                    16'(act_s.frame_accepted));
        check_field("echo_byte", 16'(exp_s.echo_byte), 16'(act_s.echo_byte));
        check_field("command_code", 16'(exp_s.command_code), 16'(act_s.command_code));
        check_field("command_value", exp_s.command_value, act_s.command_value);
        check_field("device_mask", 16'(exp_s.device_mask), 16'(act_s.device_mask));
        check_field("fan_on", 16'(exp_s.fan_on), 16'(act_s.fan_on));
        check_field("heater_on", 16'(exp_s.heater_on), 16'(act_s.heater_on));
        check_field("light_duty", 16'(exp_s.light_duty), 16'(act_s.light_duty));
        check_field("light_color", 16'(exp_s.light_color), 16'(act_s.light_color));
        check_field("fertilizer_on", 16'(exp_s.fertilizer_on),
                    16'(act_s.fertilizer_on));
        check_field("water_on", 16'(exp_s.water_on), 16'(act_s.water_on));
        check_field("pad", 16'(exp_s.pad), 16'(act_s.pad));
      end
    end
  end

  // result side back-pressure, switching between modes of random length
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(8, 64);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:   out_tready <= 1'b1;
      RX_RANDOM: out_tready <= 1'($urandom_range(0, 1));
      RX_SLOW:   out_tready <= ($urandom_range(0, 3) == 0);
      default:   out_tready <= ~out_tready;
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // valid stays up inside a burst; a gap lowers it for a random spell
  task automatic send_word(logic kind, logic [7:0] value);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    word_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic send_tick();
    send_word(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  // sends the first 'cut' words of a frame, with ticks slipped in if asked
  task automatic send_frame(logic [7:0] cmd, logic [7:0] hi, logic [7:0] lo,
                            bit mix_ticks = 0, int cut = 9);
    logic [7:0] frame_bytes [9];
    frame_bytes = '{SYNC0, SYNC1, SYNC2, cmd, hi, lo, TRAIL0, TRAIL1, TRAIL2};
    for (int i = 0; i < cut; i++) begin
      if (mix_ticks && i > 0 && $urandom_range(0, 3) == 0) send_tick();
      send_word(KIND_BYTE, frame_bytes[i]);
    end
  endtask

  task automatic idle_and_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(logic [0:0] idx, logic [15:0] value);
    idle_and_drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FERT_TICKS) fert_reload = value;
    else water_reload = value;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_low();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return 8'h00;
    if (roll < 40) return 8'hFF;
    if (roll < 60) return 8'($urandom_range(1, 12));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_directed();
    // level far above ten: duty uses ten once the light is on
    send_frame({3'd0, CMD_LEVEL}, 8'hFF, 8'hFF);
    send_frame({3'd0, CMD_LIGHT}, 8'h00, 8'h01);
    // repeated start byte: the second one fails and is not a new start
    send_word(KIND_BYTE, SYNC0);
    send_word(KIND_BYTE, SYNC0);
    send_word(KIND_BYTE, SYNC1);
    send_word(KIND_BYTE, SYNC2);
    send_word(KIND_BYTE, CMD_MAX);
    send_tick();
    send_word(KIND_TICK, 8'hFF);
    idle_and_drain();
  endtask

  task automatic test_pump_countdown();
    write_register(REG_FERT_TICKS, 16'd1);
    write_register(REG_WATER_TICKS, 16'd2);
    send_frame({3'd0, CMD_FERT}, 8'h00, 8'h01);
    send_frame({3'd0, CMD_WATER}, 8'hFF, 8'h80, 1);
    repeat (4) send_tick();
    idle_and_drain();
  endtask

  task automatic test_random_traffic();
    logic [15:0] fert_val, water_val;
    int          target, roll, n;
    logic [7:0]  cmd;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin fert_val = 16'd3;     water_val = 16'd7;     end
        1: begin fert_val = 16'd0;     water_val = 16'hFFFF;  end
        2: begin fert_val = 16'hFFFF;  water_val = 16'd0;     end
        3: begin fert_val = 16'($urandom_range(1, 16));
                 water_val = 16'($urandom_range(1, 16)); end
        default: begin fert_val = TICKS_RESET; water_val = 16'd1; end
      endcase
      write_register(REG_FERT_TICKS, fert_val);
      write_register(REG_WATER_TICKS, water_val);
      target = word_count + PHASE_WORDS;
      while (word_count < target) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 85) cmd = 8'($urandom_range(0, 20));
        else cmd = 8'($urandom_range(21, 255));
        if (roll < 65) begin
          send_frame(cmd, 8'($urandom_range(0, 255)), pick_low(),
                     $urandom_range(0, 9) == 0);
        end else if (roll < 80) begin
          n = $urandom_range(1, 10);
          repeat (n) send_tick();
        end else if (roll < 92) begin
          send_frame(cmd, 8'($urandom_range(0, 255)), pick_low(), 0,
                     $urandom_range(1, 8));
          send_word(KIND_BYTE, 8'($urandom_range(0, 255)));
        end else begin
          n = $urandom_range(1, 6);
          repeat (n) send_word(KIND_BYTE, 8'($urandom_range(0, 255)));
        end
      end
    end
    idle_and_drain();
  endtask

  initial begin
    clear_receiver_state();
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_FERT_TICKS;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= KIND_BYTE;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_pump_countdown();
    test_random_traffic();

    if (error_count == 0 && pending_status.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
